/* src/paired_context_submit_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// paired context submit scheduler assertion macros
// immediate and next-cycle implication checks clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef PAIRED_CONTEXT_SUBMIT_SCHEDULER_DEFINES_SVH
`define PAIRED_CONTEXT_SUBMIT_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define PCSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcss implication check failed");
`define PCSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcss next-cycle check failed");
`else
`define PCSS_ASSERT_IMP(lbl, ante, cons)
`define PCSS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/pcss_pkg.sv */
// ----------------------------------------------------------------------------
// pcss_pkg
// shared types and constants of the paired context submit scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcss_pkg;

  localparam int unsigned CtxW    = 8;
  localparam int unsigned TailW   = 17;
  localparam int unsigned TagW    = 16;
  localparam int unsigned StatusW = 16;
  localparam int unsigned CmdW    = 3;

  localparam int unsigned StActiveIdleBit    = 3;
  localparam int unsigned StElementSwitchBit = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD     = 3'd0,
    CMD_STATUS  = 3'd1,
    CMD_END     = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_SUSPEND = 3'd4,
    CMD_RESUME  = 3'd5,
    CMD_FLUSH   = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [CtxW-1:0]  ctx;
    logic [TailW-1:0] tail;
  } pend_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } queue_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

`default_nettype wire

/* src/paired_context_submit_scheduler.sv */
// ----------------------------------------------------------------------------
// paired_context_submit_scheduler
// pending request fifo drained into a two-slot submission port
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A query, suspend, flush or unused
// command goes straight to the finish state, where its result is registered.
// A command that tries to submit alternates between fetch and merge, one
// fifo entry drained per pass, until the fifo is empty, a suspend or two
// in-flight submissions hold it, or a third context stops the drain; each
// pass waits on the fifo's single registered read port, and the merge and
// tag unit handles one entry per read. The input is ready again once the
// result is registered. The result register lets the next transaction be
// taken while a result waits on m_axis_tready; a later result waits for it.
`timescale 1ns / 1ps
`default_nettype none
`include "paired_context_submit_scheduler_defines.svh"

module paired_context_submit_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // ctx_id, tail_ptr, event_status, event_tag, query_tag, zero fill
  input  wire  [79:0] s_axis_tdata,
  // command
  input  wire  [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // submit_valid, first_ctx, first_tail, first_tag, second_valid,
  // second_ctx, second_tail, second_tag, query_done, queue_full, zero fill
  output logic [87:0] m_axis_tdata
);

  localparam int unsigned CtxW  = pcss_pkg::CtxW;
  localparam int unsigned TailW = pcss_pkg::TailW;
  localparam int unsigned TagW  = pcss_pkg::TagW;
  localparam int unsigned StW   = pcss_pkg::StatusW;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_MERGE, S_FINISH} state_e;

  state_e state_q, state_d;

  logic [TagW-1:0]  tag_q, tag_d;
  logic [TagW-1:0]  ctag_q, ctag_d;
  logic [1:0]       infl_q, infl_d;
  logic             susp_q, susp_d;
  logic             mvalid_q, mvalid_d;

  logic             used0_q, used0_d, used1_q, used1_d, slot_q, slot_d;
  logic [CtxW-1:0]  ctx0_q, ctx0_d, ctx1_q, ctx1_d;
  logic [TailW-1:0] tail0_q, tail0_d, tail1_q, tail1_d;
  logic [TagW-1:0]  stag0_q, stag0_d, stag1_q, stag1_d;
  logic             qfull_q, qfull_d, cmpl_q, cmpl_d;
  logic [87:0]      mdata_q, mdata_d;

  logic                  s_accept;
  pcss_pkg::cmd_e        cmd;
  logic [CtxW-1:0]       in_ctx;
  logic [TailW-1:0]      in_tail;
  logic [StW-1:0]        in_status;
  logic [TagW-1:0]       in_etag, in_qtag;
  pcss_pkg::queue_ctrl_t q_ctrl;
  pcss_pkg::pend_entry_t q_wr, q_rd;
  pcss_pkg::queue_stat_t q_stat;

  logic             cur_used, hit;
  logic [CtxW-1:0]  cur_ctx;
  logic [TagW-1:0]  tag_inc, fresh_tag, tag_diff;
  logic [2:0]       infl_sum;

  assign cmd       = pcss_pkg::cmd_e'(s_axis_tuser);
  assign in_ctx    = s_axis_tdata[7:0];
  assign in_tail   = s_axis_tdata[24:8];
  assign in_status = s_axis_tdata[40:25];
  assign in_etag   = s_axis_tdata[56:41];
  assign in_qtag   = s_axis_tdata[72:57];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign q_wr.ctx      = in_ctx;
  assign q_wr.tail     = in_tail;

  pcss_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (q_ctrl),
    .wr_entry_i (q_wr),
    .rd_entry_o (q_rd),
    .stat_o     (q_stat)
  );

  // shared merge and tag unit
  always_comb begin
    cur_used  = slot_q ? used1_q : used0_q;
    cur_ctx   = slot_q ? ctx1_q : ctx0_q;
    hit       = cur_used && (cur_ctx == q_rd.ctx);
    tag_inc   = tag_q + TagW'(1);
    fresh_tag = (tag_inc == '0) ? TagW'(1) : tag_inc;
    tag_diff  = ctag_q - in_qtag;
    infl_sum  = {1'b0, infl_q} + {1'b0, used1_q, !used1_q};
  end

  always_comb begin
    state_d  = state_q;
    tag_d    = tag_q;
    ctag_d   = ctag_q;
    infl_d   = infl_q;
    susp_d   = susp_q;
    mvalid_d = mvalid_q && !m_axis_tready;
    used0_d  = used0_q;
    used1_d  = used1_q;
    slot_d   = slot_q;
    ctx0_d   = ctx0_q;
    ctx1_d   = ctx1_q;
    tail0_d  = tail0_q;
    tail1_d  = tail1_q;
    stag0_d  = stag0_q;
    stag1_d  = stag1_q;
    qfull_d  = qfull_q;
    cmpl_d   = cmpl_q;
    mdata_d  = mdata_q;
    q_ctrl   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          used0_d = 1'b0;
          used1_d = 1'b0;
          slot_d  = 1'b0;
          ctx0_d  = '0;
          ctx1_d  = '0;
          tail0_d = '0;
          tail1_d = '0;
          stag0_d = '0;
          stag1_d = '0;
          qfull_d = 1'b0;
          cmpl_d  = 1'b0;
          state_d = S_FINISH;
          case (cmd)
            pcss_pkg::CMD_ADD: begin
              if (q_stat.full) begin
                qfull_d = 1'b1;
              end else begin
                q_ctrl.push = 1'b1;
              end
              state_d = S_FETCH;
            end
            pcss_pkg::CMD_STATUS: begin
              if (in_status[pcss_pkg::StActiveIdleBit] ||
                  in_status[pcss_pkg::StElementSwitchBit]) begin
                ctag_d = in_etag;
                if (infl_q != '0) begin
                  infl_d = infl_q - 2'd1;
                end
              end
              state_d = S_FETCH;
            end
            pcss_pkg::CMD_END: begin
              state_d = S_FETCH;
            end
            pcss_pkg::CMD_QUERY: begin
              cmpl_d = !tag_diff[TagW-1];
            end
            pcss_pkg::CMD_SUSPEND: begin
              susp_d = 1'b1;
            end
            pcss_pkg::CMD_RESUME: begin
              susp_d  = 1'b0;
              infl_d  = '0;
              state_d = S_FETCH;
            end
            pcss_pkg::CMD_FLUSH: begin
              q_ctrl.flush = 1'b1;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (susp_q || infl_q[1] || q_stat.empty) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (hit) begin
          if (slot_q) begin
            tail1_d = q_rd.tail;
          end else begin
            tail0_d = q_rd.tail;
          end
          q_ctrl.pop = 1'b1;
          state_d    = S_FETCH;
        end else if (cur_used && slot_q) begin
          state_d = S_FINISH;
        end else begin
          tag_d = fresh_tag;
          if (cur_used) begin
            slot_d  = 1'b1;
            used1_d = 1'b1;
            ctx1_d  = q_rd.ctx;
            tail1_d = q_rd.tail;
            stag1_d = fresh_tag;
          end else begin
            used0_d = 1'b1;
            ctx0_d  = q_rd.ctx;
            tail0_d = q_rd.tail;
            stag0_d = fresh_tag;
          end
          q_ctrl.pop = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_FINISH: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = {2'b00, qfull_q, cmpl_q, stag1_q, tail1_q, ctx1_q, used1_q,
                      stag0_q, tail0_q, ctx0_q, used0_q};
          if (used0_q) begin
            infl_d = infl_sum[2] ? 2'd3 : infl_sum[1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tag_q    <= '0;
      ctag_q   <= '0;
      infl_q   <= '0;
      susp_q   <= 1'b1;
      mvalid_q <= 1'b0;
      used0_q  <= 1'b0;
      used1_q  <= 1'b0;
      slot_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      tag_q    <= tag_d;
      ctag_q   <= ctag_d;
      infl_q   <= infl_d;
      susp_q   <= susp_d;
      mvalid_q <= mvalid_d;
      used0_q  <= used0_d;
      used1_q  <= used1_d;
      slot_q   <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx0_q  <= ctx0_d;
    ctx1_q  <= ctx1_d;
    tail0_q <= tail0_d;
    tail1_q <= tail1_d;
    stag0_q <= stag0_d;
    stag1_q <= stag1_d;
    qfull_q <= qfull_d;
    cmpl_q  <= cmpl_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  `PCSS_ASSERT_NXT(a_busy_after_accept, s_accept, !s_axis_tready)
  `PCSS_ASSERT_IMP(a_second_needs_first, m_axis_tvalid && mdata_q[42], mdata_q[0])
  `PCSS_ASSERT_IMP(a_query_no_submit, m_axis_tvalid && mdata_q[84], !mdata_q[0] && !mdata_q[85])
  `PCSS_ASSERT_IMP(a_slot1_after_slot0, used1_q, used0_q)

endmodule

`default_nettype wire

/* src/pcss_queue.sv */
// ----------------------------------------------------------------------------
// pcss_queue
// pending request fifo: one write port at the tail, registered read of head
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcss_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  pcss_pkg::queue_ctrl_t ctrl_i,
  input  pcss_pkg::pend_entry_t wr_entry_i,
  output pcss_pkg::pend_entry_t rd_entry_o,
  output pcss_pkg::queue_stat_t stat_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [IdxW:0]   DepthSum = (IdxW + 1)'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(QUEUE_DEPTH - 1);

  pcss_pkg::pend_entry_t mem [QUEUE_DEPTH];
  pcss_pkg::pend_entry_t rd_q;

  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW:0]   tail_sum;
  logic [IdxW-1:0] wr_idx;

  // tail index wraps modulo the depth
  always_comb begin
    tail_sum = (IdxW + 1)'(head_q) + (IdxW + 1)'(count_q);
    if (tail_sum >= DepthSum) begin
      wr_idx = IdxW'(tail_sum - DepthSum);
    end else begin
      wr_idx = tail_sum[IdxW-1:0];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.flush) begin
      count_d = '0;
    end else if (ctrl_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CntW'(1);
      head_d  = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.flush) begin
      mem[wr_idx] <= wr_entry_i;
    end
    rd_q <= mem[head_q];
  end

  assign rd_entry_o   = rd_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q >= DepthCnt);

endmodule

`default_nettype wire
